// File: rtl/core/evg_pkg.sv
// Shared types, constants and the ln2 series table for the exponential variate generator.
package evg_pkg;

    // Field and datapath widths.
    localparam int UNIFORM_BITS  = 32;
    localparam int SCALE_BITS    = 24;
    localparam int VARIATE_BITS  = 40;
    localparam int CNT_BITS      = 6;
    localparam int LZ_BITS       = 5;
    localparam int MAC_BITS      = 32;
    localparam int ACC_BITS      = 64;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_BITS      = 4;
    localparam int NORM_STEPS    = 5;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET   = 24'd65536;
    localparam logic [IDX_BITS-1:0]   LAST_IDX      = 4'd15;
    localparam logic [2:0]            NORM_LAST     = 3'd4;
    localparam logic [LZ_BITS:0]      NORM_FIRST_SH = 6'd16;

    // ln2 in Q0.64, truncated, and its two 32-bit halves.
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
    localparam logic [31:0] LN2_HI  = 32'hB17217F7;
    localparam logic [31:0] LN2_LO  = 32'hD1CF79AB;

    // Upper 64 bits of a 64 x 64 product; evaluated only while building the table.
    function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[127:64];
    endfunction

    // Series terms ln2^k / k!, each truncated in Q0.64.
    localparam logic [63:0] TERM_1  = LN2_Q64;
    localparam logic [63:0] TERM_2  = mul_hi64(TERM_1,  LN2_Q64) / 64'd2;
    localparam logic [63:0] TERM_3  = mul_hi64(TERM_2,  LN2_Q64) / 64'd3;
    localparam logic [63:0] TERM_4  = mul_hi64(TERM_3,  LN2_Q64) / 64'd4;
    localparam logic [63:0] TERM_5  = mul_hi64(TERM_4,  LN2_Q64) / 64'd5;
    localparam logic [63:0] TERM_6  = mul_hi64(TERM_5,  LN2_Q64) / 64'd6;
    localparam logic [63:0] TERM_7  = mul_hi64(TERM_6,  LN2_Q64) / 64'd7;
    localparam logic [63:0] TERM_8  = mul_hi64(TERM_7,  LN2_Q64) / 64'd8;
    localparam logic [63:0] TERM_9  = mul_hi64(TERM_8,  LN2_Q64) / 64'd9;
    localparam logic [63:0] TERM_10 = mul_hi64(TERM_9,  LN2_Q64) / 64'd10;
    localparam logic [63:0] TERM_11 = mul_hi64(TERM_10, LN2_Q64) / 64'd11;
    localparam logic [63:0] TERM_12 = mul_hi64(TERM_11, LN2_Q64) / 64'd12;
    localparam logic [63:0] TERM_13 = mul_hi64(TERM_12, LN2_Q64) / 64'd13;
    localparam logic [63:0] TERM_14 = mul_hi64(TERM_13, LN2_Q64) / 64'd14;
    localparam logic [63:0] TERM_15 = mul_hi64(TERM_14, LN2_Q64) / 64'd15;

    // Partial sums q[i] in Q0.64.
    localparam logic [63:0] SUM_1  = TERM_1;
    localparam logic [63:0] SUM_2  = SUM_1  + TERM_2;
    localparam logic [63:0] SUM_3  = SUM_2  + TERM_3;
    localparam logic [63:0] SUM_4  = SUM_3  + TERM_4;
    localparam logic [63:0] SUM_5  = SUM_4  + TERM_5;
    localparam logic [63:0] SUM_6  = SUM_5  + TERM_6;
    localparam logic [63:0] SUM_7  = SUM_6  + TERM_7;
    localparam logic [63:0] SUM_8  = SUM_7  + TERM_8;
    localparam logic [63:0] SUM_9  = SUM_8  + TERM_9;
    localparam logic [63:0] SUM_10 = SUM_9  + TERM_10;
    localparam logic [63:0] SUM_11 = SUM_10 + TERM_11;
    localparam logic [63:0] SUM_12 = SUM_11 + TERM_12;
    localparam logic [63:0] SUM_13 = SUM_12 + TERM_13;
    localparam logic [63:0] SUM_14 = SUM_13 + TERM_14;
    localparam logic [63:0] SUM_15 = SUM_14 + TERM_15;

    // A remainder r with zero low bits beats q[i] exactly when r exceeds the top word
    // of q[i]. The last entry stands for 1.0 and is never compared.
    localparam logic [31:0] Q_HI [TABLE_ENTRIES] = '{
        SUM_1[63:32],  SUM_2[63:32],  SUM_3[63:32],  SUM_4[63:32],
        SUM_5[63:32],  SUM_6[63:32],  SUM_7[63:32],  SUM_8[63:32],
        SUM_9[63:32],  SUM_10[63:32], SUM_11[63:32], SUM_12[63:32],
        SUM_13[63:32], SUM_14[63:32], SUM_15[63:32], 32'hFFFFFFFF
    };

    // True when the remainder (Q1.32) is above table entry idx.
    function automatic logic exceeds(input logic [UNIFORM_BITS:0] r,
                                     input logic [IDX_BITS-1:0] idx);
        logic res;
        if (idx == LAST_IDX) begin
            res = 1'b0;
        end
        else if (r[UNIFORM_BITS]) begin
            res = 1'b1;
        end
        else begin
            res = (r[UNIFORM_BITS-1:0] > Q_HI[idx]);
        end
        return res;
    endfunction

    // Algorithm phase between accepted words.
    typedef enum logic [1:0] {
        PH_FIRST     = 2'd0,
        PH_MIN_FIRST = 2'd1,
        PH_MIN_MORE  = 2'd2
    } phase_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_CHECK,
        ST_LN2_LO,
        ST_LN2_HI,
        ST_SUM,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_DONE
    } seq_state_t;

endpackage

// File: rtl/core/evg_if.sv
// Valid/ready channel interfaces for uniform words in and variates out.
interface evg_sample_if;
    import evg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [UNIFORM_BITS-1:0] uniform_word;
    modport source (output valid, output uniform_word, input ready);
    modport sink (input valid, input uniform_word, output ready);
endinterface

interface evg_result_if;
    import evg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [VARIATE_BITS-1:0] variate;
    modport source (output valid, output variate, input ready);
    modport sink (input valid, input variate, output ready);
endinterface

// File: rtl/core/evg_mac.sv
// Shared 32 x 32 multiply-accumulate unit with a registered 64-bit result.
module evg_mac (
    input  logic                          clk,
    input  logic                          en,
    input  logic [evg_pkg::MAC_BITS-1:0]  a,
    input  logic [evg_pkg::MAC_BITS-1:0]  b,
    input  logic [evg_pkg::ACC_BITS-1:0]  addend,
    output logic [evg_pkg::ACC_BITS-1:0]  acc
);
    import evg_pkg::*;

    logic [ACC_BITS-1:0] acc_reg;
    logic [ACC_BITS-1:0] acc_next;

    // The product of two 32-bit words plus a 32-bit-scale addend always fits 64 bits.
    always_comb
    begin
        acc_next = {{(ACC_BITS-MAC_BITS){1'b0}}, a} * {{(ACC_BITS-MAC_BITS){1'b0}}, b}
                   + addend;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/core/exponential_variate_generator_core.sv
// Top level of the exponential variate generator (algorithm SA, fixed point).
//
// Takes uniform Q0.32 words one beat at a time and returns exponential variates in
// Q16.24, scaled by the Q8.16 mean in the scale register (reset 1.0). A zero first
// word is dropped. A first word is normalized by a five-step leading-zero search,
// one step a cycle, then checked against ln2 in the check state. If the search for a
// minimum is needed, each further word is compared in the idle state as it is taken;
// the word that ends the search, or a first word that ends at once, starts the
// finishing sequence on one shared 32 x 32 multiply-accumulate unit (two passes for
// min*ln2, one for count*ln2 plus fraction, two for the scaling), and the result is
// loaded into the output register once it is free. Words are not taken while the
// sequencer runs. The output register lets the next word be taken while a variate
// waits to be read.
module exponential_variate_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [evg_pkg::SCALE_BITS-1:0]  cfg_wdata,
    evg_sample_if.sink                      sample,
    evg_result_if.source                    result
);
    import evg_pkg::*;

    // Control and algorithm state.
    seq_state_t                state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [IDX_BITS-1:0]       idx_reg, idx_next;
    logic [UNIFORM_BITS-1:0]   min_reg, min_next;
    logic [UNIFORM_BITS:0]     rem_reg, rem_next;
    logic [CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic [2:0]                step_reg, step_next;
    logic [SCALE_BITS-1:0]     scale_reg, scale_next;
    logic                      out_valid_reg, out_valid_next;

    // Working registers.
    logic [UNIFORM_BITS-1:0]   norm_reg, norm_next;
    logic [LZ_BITS-1:0]        lz_reg, lz_next;
    logic                      use_min_reg, use_min_next;
    logic [CNT_BITS-1:0]       ehi_reg, ehi_next;
    logic [7:0]                lob_reg, lob_next;
    logic [VARIATE_BITS-1:0]   out_data_reg, out_data_next;

    // Shared unit operands.
    logic                      mac_en;
    logic [MAC_BITS-1:0]       mac_a;
    logic [MAC_BITS-1:0]       mac_b;
    logic [ACC_BITS-1:0]       mac_add;
    logic [ACC_BITS-1:0]       acc;

    // Helpers.
    logic                      accept;
    logic [UNIFORM_BITS-1:0]   word;
    logic [UNIFORM_BITS-1:0]   new_min;
    logic [IDX_BITS-1:0]       idx_inc;
    logic [LZ_BITS:0]          shamt;
    logic [LZ_BITS:0]          rsh;
    logic                      top_zero;
    logic                      pow2;
    logic [UNIFORM_BITS:0]     first_rem;

    evg_mac u_mac (
        .clk    (clk),
        .en     (mac_en),
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_add),
        .acc    (acc)
    );

    assign sample.ready  = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.variate = out_data_reg;

    assign accept = sample.valid && (state_reg == ST_IDLE);
    assign word   = sample.uniform_word;

    // Running minimum and saturating table index for the search phase.
    assign new_min = (word < min_reg) ? word : min_reg;
    assign idx_inc = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;

    // One binary step of the leading-zero search: 16, 8, 4, 2, then 1 bit.
    assign shamt    = NORM_FIRST_SH >> step_reg;
    assign rsh      = (LZ_BITS+1)'(UNIFORM_BITS) - shamt;
    assign top_zero = ((norm_reg >> rsh) == '0);

    // After normalization, a power of two leaves a remainder of exactly 1.0.
    assign pow2      = (norm_reg[UNIFORM_BITS-2:0] == '0);
    assign first_rem = pow2 ? {1'b1, {UNIFORM_BITS{1'b0}}}
                            : {1'b0, norm_reg[UNIFORM_BITS-2:0], 1'b0};

    // Sequencer: next state, algorithm state and shared unit operands.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        min_next       = min_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        scale_next     = cfg_we ? cfg_wdata : scale_reg;
        out_valid_next = out_valid_reg && !result.ready;
        norm_next      = norm_reg;
        lz_next        = lz_reg;
        use_min_next   = use_min_reg;
        ehi_next       = ehi_reg;
        lob_next       = lob_reg;
        out_data_next  = out_data_reg;
        mac_en         = 1'b0;
        mac_a          = '0;
        mac_b          = '0;
        mac_add        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_MIN_FIRST:
                        begin
                            min_next   = word;
                            idx_next   = '0;
                            phase_next = PH_MIN_MORE;
                        end
                        PH_MIN_MORE:
                        begin
                            min_next = new_min;
                            idx_next = idx_inc;
                            if (!exceeds(rem_reg, idx_inc))
                            begin
                                phase_next   = PH_FIRST;
                                use_min_next = 1'b1;
                                state_next   = ST_LN2_LO;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_FIRST;
                            if (word != '0)
                            begin
                                norm_next  = word;
                                lz_next    = '0;
                                step_next  = '0;
                                state_next = ST_NORM;
                            end
                        end
                    endcase
                end
            end
            ST_NORM:
            begin
                if (top_zero)
                begin
                    norm_next = norm_reg << shamt;
                    lz_next   = lz_reg + shamt[LZ_BITS-1:0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == NORM_LAST)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next = {1'b0, lz_reg} + CNT_BITS'(pow2);
                rem_next = first_rem;
                if (exceeds(first_rem, '0))
                begin
                    phase_next = PH_MIN_FIRST;
                    state_next = ST_IDLE;
                end
                else
                begin
                    use_min_next = 1'b0;
                    state_next   = ST_SUM;
                end
            end
            ST_LN2_LO:
            begin
                // Low half of min * ln2.
                mac_en     = 1'b1;
                mac_a      = min_reg;
                mac_b      = LN2_LO;
                state_next = ST_LN2_HI;
            end
            ST_LN2_HI:
            begin
                // High half with the carry word of the low half; the fraction is acc[63:32].
                mac_en     = 1'b1;
                mac_a      = min_reg;
                mac_b      = LN2_HI;
                mac_add    = {{(ACC_BITS-32){1'b0}}, acc[63:32]};
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // Unscaled variate in Q6.32: count * ln2 plus the fraction.
                mac_en     = 1'b1;
                mac_a      = MAC_BITS'(cnt_reg);
                mac_b      = LN2_HI;
                mac_add    = {{(ACC_BITS-32){1'b0}},
                              (use_min_reg ? acc[63:32] : rem_reg[UNIFORM_BITS-1:0])};
                state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO:
            begin
                // Low word of the variate times the scale; keep the high bits aside.
                ehi_next   = acc[37:32];
                mac_en     = 1'b1;
                mac_a      = acc[31:0];
                mac_b      = MAC_BITS'(scale_reg);
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI:
            begin
                lob_next   = acc[31:24];
                mac_en     = 1'b1;
                mac_a      = MAC_BITS'(ehi_reg);
                mac_b      = MAC_BITS'(scale_reg);
                mac_add    = {{(ACC_BITS-32){1'b0}}, acc[63:32]};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Load the output register once the previous beat has left.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {acc[31:0], lob_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Algorithm state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            idx_reg       <= '0;
            min_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            min_reg       <= min_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output data registers.
    always_ff @(posedge clk)
    begin
        norm_reg     <= norm_next;
        lz_reg       <= lz_next;
        use_min_reg  <= use_min_next;
        ehi_reg      <= ehi_next;
        lob_reg      <= lob_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    // The leading-zero search runs exactly five steps.
    a_norm_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (step_reg <= NORM_LAST))
        else $error("normalizer step counter overran");

    // A nonzero first word ends normalized with its top bit set.
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> norm_reg[UNIFORM_BITS-1])
        else $error("first word not normalized");

    // The doubling count never exceeds the word width.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (cnt_reg <= CNT_BITS'(UNIFORM_BITS)))
        else $error("doubling count out of range");

    // A result beat appears only after the finishing sequence.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the finishing state");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the exponential variate generator core.
`timescale 1ns / 1ps

module tb_top;
    import evg_pkg::*;

    // Fixed-point constants of the algorithm.
    localparam logic [63:0] LN2_FRAC       = 64'hB17217F7D1CF79AB;
    localparam logic [31:0] LN2_WORD       = 32'hB17217F7;
    localparam logic [32:0] ONE_Q1         = 33'h1_0000_0000;
    localparam logic [3:0]  LAST_ENTRY     = 4'd15;
    localparam logic [23:0] SCALE_AT_RESET = 24'd65536;

    // Run shape.
    localparam int SETTLE_CYCLES     = 20;
    localparam int WORDS_PER_SETTING = 210;
    localparam int NUM_SETTINGS      = 6;
    localparam int LONG_HOLD         = 300;
    localparam int HOLD_AFTER_BEATS  = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [SCALE_BITS-1:0] cfg_wdata;

    evg_sample_if sample_ch ();
    evg_result_if result_ch ();

    exponential_variate_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Words waiting to be offered and variates waiting to come out.
    logic [UNIFORM_BITS-1:0] pending_words [$];
    logic [VARIATE_BITS-1:0] expected_variates [$];

    // Predictor state and its copy of the scale register.
    phase_t                pr_phase = PH_FIRST;
    logic [5:0]            pr_cnt = '0;
    logic [32:0]           pr_rem = '0;
    logic [31:0]           pr_min = '0;
    logic [3:0]            pr_idx = '0;
    logic [SCALE_BITS-1:0] pr_scale;
    logic [63:0]           series_sum [16];

    int error_count = 0;
    int words_sent = 0;
    int variates_seen = 0;
    int searches_started = 0;
    int deepest_entry = 0;
    int settings_used;

    // Sender burst state and receiver stall state.
    int burst_left;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;
    int rx_beats;
    logic [5:0] pattern_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Partial sums of ln2^k/k!, each term truncated in Q0.64.
    function automatic void build_series_table();
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] tprod;
        term = LN2_FRAC;
        sum = LN2_FRAC;
        series_sum[0] = sum;
        for (int j = 2; j <= 16; j++)
        begin
            tprod = 128'(term) * 128'(LN2_FRAC);
            term = tprod[127:64] / 64'(j);
            sum = sum + term;
            series_sum[j-1] = sum;
        end
    endfunction

    // True while the remainder still lies above the table entry.
    function automatic logic above_table(input logic [32:0] r, input logic [3:0] idx);
        logic res;
        if (idx == LAST_ENTRY)
            res = 1'b0;
        else if (r[32])
            res = 1'b1;
        else
            res = ({r[31:0], 32'd0} > series_sum[idx]);
        return res;
    endfunction

    // count*ln2 plus a Q0.32 fraction, scaled by Q8.16 and truncated to Q16.24.
    function automatic logic [VARIATE_BITS-1:0] scaled_variate(input logic [31:0] frac);
        logic [63:0] unscaled;
        logic [63:0] prod;
        unscaled = 64'(pr_cnt) * 64'(LN2_WORD) + 64'(frac);
        prod = unscaled * 64'(pr_scale);
        return prod[63:24];
    endfunction

    // One accepted word through the algorithm; returns 1 when a variate results.
    function automatic logic predict_variate(input logic [31:0] w,
                                             output logic [VARIATE_BITS-1:0] v);
        logic [33:0] dbl;
        logic [5:0]  cnt;
        logic [95:0] mprod;
        logic        hit;
        hit = 1'b0;
        v = '0;
        case (pr_phase)
            PH_MIN_FIRST:
            begin
                pr_min = w;
                pr_idx = 4'd0;
                pr_phase = PH_MIN_MORE;
            end
            PH_MIN_MORE:
            begin
                if (w < pr_min)
                    pr_min = w;
                if (pr_idx != LAST_ENTRY)
                    pr_idx = pr_idx + 4'd1;
                if (int'(pr_idx) > deepest_entry)
                    deepest_entry = pr_idx;
                if (!above_table(pr_rem, pr_idx))
                begin
                    mprod = 96'(pr_min) * 96'(LN2_FRAC);
                    v = scaled_variate(mprod[95:64]);
                    hit = 1'b1;
                    pr_phase = PH_FIRST;
                end
            end
            default:
            begin
                pr_phase = PH_FIRST;
                if (w != '0)
                begin
                    // Double until the word passes one; each doubling short of it is one ln2.
                    cnt = 6'd0;
                    dbl = {2'b00, w} << 1;
                    while (dbl <= 34'(ONE_Q1))
                    begin
                        cnt = cnt + 6'd1;
                        dbl = dbl << 1;
                    end
                    pr_cnt = cnt;
                    pr_rem = 33'(dbl - 34'(ONE_Q1));
                    if (!above_table(pr_rem, 4'd0))
                    begin
                        v = scaled_variate(pr_rem[31:0]);
                        hit = 1'b1;
                    end
                    else
                    begin
                        pr_phase = PH_MIN_FIRST;
                        searches_started++;
                    end
                end
            end
        endcase
        return hit;
    endfunction

    // Random word: plain, leading-zero, near-one, power-of-two, zero and small words.
    function automatic logic [31:0] rand_word();
        int sel;
        logic [31:0] w;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            w = $urandom();
        else if (sel < 60)
            w = $urandom() >> $urandom_range(1, 31);
        else if (sel < 78)
            w = (32'hFFFFFFFF ^ ($urandom() >> $urandom_range(6, 31))) >> $urandom_range(0, 3);
        else if (sel < 88)
            w = 32'd1 << $urandom_range(0, 31);
        else if (sel < 95)
            w = '0;
        else
            w = $urandom_range(1, 255);
        return w;
    endfunction

    // Waits until every word is taken and every variate has come, then lets the block settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || sample_ch.valid || expected_variates.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Feeds single words until a variate in progress is complete.
    task automatic close_open_variate();
        while (pr_phase != PH_FIRST)
        begin
            pending_words.push_back(rand_word());
            wait_drained();
        end
    endtask

    task automatic write_scale(input logic [SCALE_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pr_scale = val;
        settings_used++;
    endtask

    // Sender: offers pending words in bursts, predicting each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        logic [VARIATE_BITS-1:0] v;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.uniform_word <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                words_sent++;
                if (predict_variate(sample_ch.uniform_word, v))
                    expected_variates.push_back(v);
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    sample_ch.valid <= 1'b1;
                    sample_ch.uniform_word <= pending_words.pop_front();
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: free-running stretches, random stalls, and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : variate_receiver
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
            rx_beats = 0;
            pattern_cnt = '0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                rx_beats++;
            pattern_cnt = pattern_cnt + 6'd1;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!hold_done && rx_beats >= HOLD_AFTER_BEATS)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end
            else if (pattern_cnt[5:4] == 2'b00)
            begin
                result_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 8);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Monitor: each variate beat is checked against the oldest prediction.
    always @(posedge clk)
    begin : variate_monitor
        logic [VARIATE_BITS-1:0] exp_v;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            variates_seen++;
            if (expected_variates.size() == 0)
            begin
                $error("variate beat with no prediction waiting: actual %h", result_ch.variate);
                error_count++;
            end
            else
            begin
                exp_v = expected_variates.pop_front();
                if (result_ch.variate !== exp_v)
                begin
                    $error("variate mismatch: expected %h, actual %h", exp_v,
                           result_ch.variate);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : test_sequence
        logic [SCALE_BITS-1:0] val;
        logic [SCALE_BITS-1:0] scale_plan [NUM_SETTINGS];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        settings_used = 0;
        pr_scale = SCALE_AT_RESET;
        build_series_table();
        scale_plan = '{24'd0, 24'hFFFFFF, 24'd1, 24'd0, SCALE_AT_RESET, 24'd0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset scale. A zero first word is dropped.
        pending_words.push_back(32'h00000000);
        // Tiny remainder, done at once.
        pending_words.push_back(32'h80000001);
        // Remainders just under and just over ln2.
        pending_words.push_back(32'hD8B90BFB);
        pending_words.push_back(32'hD8B90BFC);
        // Zero words in both minimum phases.
        pending_words.push_back(32'h00000000);
        pending_words.push_back(32'h00000000);
        // Smallest word: most doublings, remainder exactly one, search to the last entry.
        pending_words.push_back(32'h00000001);
        pending_words.push_back(32'hFFFFFFFF);
        for (int k = 0; k < 15; k++)
            pending_words.push_back($urandom());
        wait_drained();
        close_open_variate();

        // Random words under several scale settings, extremes included.
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            if (p == 3 || p == 5)
                val = SCALE_BITS'($urandom());
            else
                val = scale_plan[p];
            write_scale(val);
            for (int k = 0; k < WORDS_PER_SETTING; k++)
                pending_words.push_back(rand_word());
            wait_drained();
            close_open_variate();
        end

        $display("Run covered %0d uniform words and %0d variates over %0d scale settings.",
                 words_sent, variates_seen, settings_used);
        $display("Minimum search entered %0d times, reaching table entry %0d at its deepest.",
                 searches_started, deepest_entry);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
